@@ design/crsf_pkg.sv @@
// ----------------------------------------------------------------------------
// crsf_pkg
// shared constants, codes and types of the serial frame parser
// ----------------------------------------------------------------------------
package crsf_pkg;

	// frame geometry
	localparam int MAX_FRAME_LEN = 64;
	localparam int STORE_DEPTH   = MAX_FRAME_LEN - 1;
	localparam int STORE_AW      = $clog2(STORE_DEPTH);
	localparam int CNT_W         = $clog2(MAX_FRAME_LEN);

	// field widths
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// crc-8, poly 0xd5, msb first
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;
	localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

	// hard length limits: type plus check, and the buffer size plus check
	localparam logic [BYTE_W:0] MIN_LEN_BYTE = 9'd2;
	localparam logic [BYTE_W:0] MAX_LEN_BYTE = (BYTE_W + 1)'(MAX_FRAME_LEN);

	typedef enum logic [1:0] {
		PH_SEEK = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_REJECT = 2'd1,
		ST_FRAME  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYNC_BYTE  = 2'd0,
		CFG_MIN_LENGTH = 2'd1,
		CFG_MAX_LENGTH = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_byte;
		logic [LEN_W-1:0]  min_length;
		logic [LEN_W-1:0]  max_length;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] frame_type;
		logic [LEN_W-1:0]  frame_length;
	} result_t;

endpackage

@@ design/crsf_if.sv @@
// ----------------------------------------------------------------------------
// crsf interfaces
// valid/ready channels for received bytes and parser results
// ----------------------------------------------------------------------------
interface crsf_byte_if;
	logic                           valid;
	logic                           ready;
	logic [crsf_pkg::BYTE_W-1:0]    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crsf_result_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [crsf_pkg::BYTE_W-1:0]    frame_type;
	logic [crsf_pkg::LEN_W-1:0]     frame_length;

	modport source (output valid, output status, output frame_type, output frame_length,
		input ready);
	modport sink   (input valid, input status, input frame_type, input frame_length,
		output ready);
endinterface

@@ design/crsf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// crsf_cfg_regs
// configuration registers: sync byte and length bounds
// ----------------------------------------------------------------------------
module crsf_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [crsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crsf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output crsf_pkg::cfg_t                    cfg
);

	crsf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte  <= 8'd200;
			cfg_q.min_length <= 7'd2;
			cfg_q.max_length <= 7'd62;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				crsf_pkg::CFG_SYNC_BYTE:  cfg_q.sync_byte  <= cfg_wdata[crsf_pkg::BYTE_W-1:0];
				crsf_pkg::CFG_MIN_LENGTH: cfg_q.min_length <= cfg_wdata[crsf_pkg::LEN_W-1:0];
				crsf_pkg::CFG_MAX_LENGTH: cfg_q.max_length <= cfg_wdata[crsf_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/crsf_crc8.sv @@
// ----------------------------------------------------------------------------
// crsf_crc8
// one-byte crc-8 update, unrolled over the eight bits
// ----------------------------------------------------------------------------
module crsf_crc8 (
	input  logic [crsf_pkg::BYTE_W-1:0] crc_in,
	input  logic [crsf_pkg::BYTE_W-1:0] data,
	output logic [crsf_pkg::BYTE_W-1:0] crc_out
);

	always_comb begin
		logic [crsf_pkg::BYTE_W-1:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < crsf_pkg::BYTE_W; i++) begin
			if ((c & crsf_pkg::CRC_TOP) != '0)
				c = (c << 1) ^ crsf_pkg::CRC_POLY;
			else
				c = c << 1;
		end
		crc_out = c;
	end

endmodule

@@ design/crsf_parse_core.sv @@
// ----------------------------------------------------------------------------
// crsf_parse_core
// frame state machine, running crc, frame buffer and result decode
// ----------------------------------------------------------------------------
module crsf_parse_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crsf_pkg::cfg_t                cfg,
	input  logic                          fire,
	input  logic [crsf_pkg::BYTE_W-1:0]   rx_byte,
	output crsf_pkg::result_t             res
);

	crsf_pkg::phase_t                   phase_q, phase_d;
	logic [crsf_pkg::LEN_W-1:0]         length_held_q;
	logic [crsf_pkg::CNT_W-1:0]         bytes_stored_q;
	logic [crsf_pkg::BYTE_W-1:0]        running_check_q;
	logic [crsf_pkg::BYTE_W-1:0]        last_type_q;
	logic [crsf_pkg::BYTE_W-1:0]        frame_store [crsf_pkg::STORE_DEPTH];

	logic [crsf_pkg::BYTE_W-1:0]        crc_next;
	logic                               len_ok;
	logic                               store_more;
	logic                               store_en;
	logic                               take_len;

	crsf_crc8 u_crc (
		.crc_in  (running_check_q),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	// length byte inside the hard limits and the configured window
	assign len_ok = ({1'b0, rx_byte} >= crsf_pkg::MIN_LEN_BYTE)
		&& ({1'b0, rx_byte} <= crsf_pkg::MAX_LEN_BYTE)
		&& (rx_byte >= {1'b0, cfg.min_length})
		&& (rx_byte <= {1'b0, cfg.max_length});

	// still short of length-1 stored bytes
	assign store_more = (crsf_pkg::LEN_W'(bytes_stored_q) + crsf_pkg::LEN_W'(1))
		< length_held_q;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			crsf_pkg::PH_LEN: begin
				phase_d = len_ok ? crsf_pkg::PH_DATA : crsf_pkg::PH_SEEK;
			end
			crsf_pkg::PH_DATA: begin
				if (!store_more)
					phase_d = crsf_pkg::PH_SEEK;
			end
			default: begin
				phase_d = (rx_byte == cfg.sync_byte) ? crsf_pkg::PH_LEN : crsf_pkg::PH_SEEK;
			end
		endcase
	end

	// result and datapath enables
	always_comb begin
		res.status       = crsf_pkg::ST_NONE;
		res.frame_type   = '0;
		res.frame_length = '0;
		store_en         = 1'b0;
		take_len         = 1'b0;
		unique case (phase_q)
			crsf_pkg::PH_LEN: begin
				if (len_ok)
					take_len = 1'b1;
				else
					res.status = crsf_pkg::ST_REJECT;
			end
			crsf_pkg::PH_DATA: begin
				if (store_more) begin
					store_en = 1'b1;
				end else if (running_check_q != rx_byte) begin
					res.status = crsf_pkg::ST_REJECT;
				end else begin
					res.status       = crsf_pkg::ST_FRAME;
					res.frame_type   = last_type_q;
					res.frame_length = length_held_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= crsf_pkg::PH_SEEK;
			length_held_q   <= '0;
			bytes_stored_q  <= '0;
			running_check_q <= '0;
			last_type_q     <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			if (take_len) begin
				length_held_q   <= rx_byte[crsf_pkg::LEN_W-1:0];
				bytes_stored_q  <= '0;
				running_check_q <= '0;
			end
			if (store_en) begin
				running_check_q <= crc_next;
				bytes_stored_q  <= bytes_stored_q + crsf_pkg::CNT_W'(1);
				if (bytes_stored_q == '0)
					last_type_q <= rx_byte;
			end
		end
	end

	// frame buffer, type byte and payload
	always_ff @(posedge clk) begin
		if (fire && store_en && (int'(bytes_stored_q) < crsf_pkg::STORE_DEPTH))
			frame_store[bytes_stored_q[crsf_pkg::STORE_AW-1:0]] <= rx_byte;
	end

	a_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == crsf_pkg::PH_DATA)
			|-> ((crsf_pkg::LEN_W'(bytes_stored_q) + crsf_pkg::LEN_W'(1)) <= length_held_q))
		else $error("stored byte count ran past the frame length");

	a_len_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == crsf_pkg::PH_DATA)
			|-> (({2'b00, length_held_q} >= crsf_pkg::MIN_LEN_BYTE)
				&& ({2'b00, length_held_q} <= crsf_pkg::MAX_LEN_BYTE)))
		else $error("held length outside the hard limits while storing");

	a_len_to_data: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (phase_q == crsf_pkg::PH_LEN) && len_ok)
			|=> ((phase_q == crsf_pkg::PH_DATA) && (bytes_stored_q == '0)
				&& (running_check_q == '0)))
		else $error("accepted length did not start a clean frame");

	a_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (res.status != crsf_pkg::ST_FRAME))
			|-> ((res.frame_type == '0) && (res.frame_length == '0)))
		else $error("type or length reported without a good frame");

endmodule

@@ design/crsf_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// crsf_frame_parser_unit
// byte-stream frame parser with length window and crc-8 (poly 0xd5) check
// ----------------------------------------------------------------------------
// Takes one received byte per item on rx and returns exactly one result item
// per byte on result: status none while hunting or collecting, rejected for a
// bad length byte or a failed check byte, frame for a good frame together with
// its type byte and length byte. Sustained rate is one byte per clock while
// result.ready stays high; an accepted byte is held in the input register and
// its result then moves into the result register, which drives the port,
// with the frame state machine and the unrolled crc update between
// them. The result register holds while result.ready is low and the
// input register keeps taking a byte as long as the result can move on, so
// back-pressure only stops rx once both registers are full. Configuration
// (sync byte, minimum and maximum length) is written on the plain write port
// and should only change while the parser is idle. The frame buffer needs no
// clearing after reset: an entry is only written, never read before write.
// ----------------------------------------------------------------------------
module crsf_frame_parser_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [crsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crsf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	crsf_byte_if.sink                         rx,
	crsf_result_if.source                     result
);

	crsf_pkg::cfg_t                 cfg;
	crsf_pkg::result_t              core_res;

	// stage 1: received byte
	logic                           valid_s1;
	logic [crsf_pkg::BYTE_W-1:0]    rx_byte_s1;

	// stage 2: result item waiting for the sink
	logic                           valid_s2;
	crsf_pkg::result_t              result_s2;

	logic                           rx_fire;
	logic                           advance_s1;

	// stage 1 moves when the result register is free or draining this cycle
	assign advance_s1 = valid_s1 && (!valid_s2 || result.ready);
	assign rx.ready   = !valid_s1 || advance_s1;
	assign rx_fire    = rx.valid && rx.ready;

	crsf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// parser state only steps when the byte leaves stage 1
	crsf_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (advance_s1),
		.rx_byte (rx_byte_s1),
		.res     (core_res)
	);

	// handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= rx_fire || (valid_s1 && !advance_s1);
			valid_s2 <= advance_s1 || (valid_s2 && !result.ready);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rx_fire)
			rx_byte_s1 <= rx.rx_byte;
		if (advance_s1)
			result_s2 <= core_res;
	end

	assign result.valid        = valid_s2;
	assign result.status       = result_s2.status;
	assign result.frame_type   = result_s2.frame_type;
	assign result.frame_length = result_s2.frame_length;

endmodule
